@@ sv/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, types and codes of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int VOICE_COUNT = 16;
   localparam int VOICE_W     = $clog2(VOICE_COUNT);
   localparam int COUNT_W     = $clog2(VOICE_COUNT + 1);
   localparam int KEY_W       = 7;
   localparam int VEL_W       = 7;
   localparam int INDEX_W     = 4;

   typedef logic [VOICE_W-1:0] voice_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VEL_W-1:0]   vel_type;

   localparam voice_type LAST_VOICE = VOICE_W'(VOICE_COUNT - 1);
   localparam count_type FULL_COUNT = COUNT_W'(VOICE_COUNT);

   typedef enum logic {
      OP_RELEASE = 1'b0,
      OP_PRESS   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      OUT_ASSIGNED  = 2'd0,
      OUT_STOLEN    = 2'd1,
      OUT_RELEASED  = 2'd2,
      OUT_NOT_FOUND = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE,
      ST_TAKE_LINK,
      ST_SCAN,
      ST_FREE_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] voice_index;
      outcome_type        outcome;
      key_type            voice_key;
      vel_type            voice_velocity;
   } result_type;

endpackage

@@ sv/pva_if.sv @@
// ----------------------------------------------------------------------------
// pva_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface pva_req_if;
   logic              valid;
   logic              ready;
   logic              opcode;
   pva_pkg::key_type  key_number;
   pva_pkg::vel_type  key_velocity;

   modport source (output valid, output opcode, output key_number, output key_velocity,
                   input ready);
   modport sink   (input valid, input opcode, input key_number, input key_velocity,
                   output ready);
endinterface

interface pva_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pva_pkg::INDEX_W-1:0]    voice_index;
   logic [1:0]                     outcome;
   pva_pkg::key_type               voice_key;
   pva_pkg::vel_type               voice_velocity;

   modport source (output valid, output voice_index, output outcome, output voice_key,
                   output voice_velocity, input ready);
   modport sink   (input valid, input voice_index, input outcome, input voice_key,
                   input voice_velocity, output ready);
endinterface

@@ sv/pva_ram.sv @@
// ----------------------------------------------------------------------------
// pva_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module pva_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ sv/pva_ctrl.sv @@
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer, list heads and link RAMs; one shared key comparator steps
// through the voices on release.
// ----------------------------------------------------------------------------
module pva_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_opcode,
   input  pva_pkg::key_type     in_key,
   input  pva_pkg::vel_type     in_vel,
   output logic                 in_ready,
   input  logic                 res_free,
   output logic                 res_load,
   output pva_pkg::result_type  res_data
);

   localparam int N = pva_pkg::VOICE_COUNT;

   pva_pkg::state_type  state_ff, state_in;
   pva_pkg::key_type    key_ff, key_in;
   pva_pkg::vel_type    vel_ff, vel_in;
   pva_pkg::voice_type  voice_ff, voice_in;
   pva_pkg::voice_type  scan_idx_ff, scan_idx_in;
   pva_pkg::voice_type  cmp_idx_ff, cmp_idx_in;
   logic                cmp_live_ff, cmp_live_in;
   logic [N-1:0]        busy_ff, busy_in;
   logic [N-1:0]        nfree_vld_ff, nfree_vld_in;
   logic [N-1:0]        nage_vld_ff, nage_vld_in;
   logic [N-1:0]        page_vld_ff, page_vld_in;
   pva_pkg::count_type  count_ff, count_in;
   pva_pkg::voice_type  ob_ff, ob_in;
   pva_pkg::voice_type  yb_ff, yb_in;
   pva_pkg::voice_type  of_ff, of_in;
   pva_pkg::voice_type  yf_ff, yf_in;
   pva_pkg::voice_type  rd_addr_ff, rd_addr_in;
   logic                rd_nfree_vld_ff, rd_nfree_vld_in;
   logic                rd_nage_vld_ff, rd_nage_vld_in;
   logic                rd_page_vld_ff, rd_page_vld_in;
   pva_pkg::result_type result_ff, result_in;

   logic                key_we;
   pva_pkg::key_type    key_rdata;
   logic                nfree_we;
   pva_pkg::voice_type  nfree_waddr, nfree_wdata, nfree_rdata;
   logic                nage_we;
   pva_pkg::voice_type  nage_waddr, nage_wdata, nage_raddr, nage_rdata;
   logic                page_we;
   pva_pkg::voice_type  page_waddr, page_wdata, page_raddr, page_rdata;

   logic                accept;
   logic                full;
   logic                empty;
   logic                hit;
   logic                last;
   pva_pkg::voice_type  take_v;
   pva_pkg::voice_type  take_tail;
   pva_pkg::voice_type  nfree_eff;
   pva_pkg::voice_type  nage_eff;
   pva_pkg::voice_type  page_eff;

   pva_ram #(.WIDTH(pva_pkg::KEY_W), .DEPTH(N)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (take_v),
      .wdata (key_ff),
      .raddr (scan_idx_ff),
      .rdata (key_rdata)
   );

   pva_ram #(.WIDTH(pva_pkg::VOICE_W), .DEPTH(N)) u_nfree_ram (
      .clock (clock),
      .we    (nfree_we),
      .waddr (nfree_waddr),
      .wdata (nfree_wdata),
      .raddr (take_v),
      .rdata (nfree_rdata)
   );

   pva_ram #(.WIDTH(pva_pkg::VOICE_W), .DEPTH(N)) u_nage_ram (
      .clock (clock),
      .we    (nage_we),
      .waddr (nage_waddr),
      .wdata (nage_wdata),
      .raddr (nage_raddr),
      .rdata (nage_rdata)
   );

   pva_ram #(.WIDTH(pva_pkg::VOICE_W), .DEPTH(N)) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (page_waddr),
      .wdata (page_wdata),
      .raddr (page_raddr),
      .rdata (page_rdata)
   );

   assign in_ready  = (state_ff == pva_pkg::ST_IDLE);
   assign accept    = in_valid && in_ready;
   assign full      = (count_ff == pva_pkg::FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign take_v    = full ? ob_ff : of_ff;
   assign take_tail = (!full && empty) ? of_ff : yb_ff;
   assign hit       = cmp_live_ff && busy_ff[cmp_idx_ff] && (key_rdata == key_ff);
   assign last      = (cmp_idx_ff == pva_pkg::LAST_VOICE);
   assign nage_raddr = (state_ff == pva_pkg::ST_TAKE) ? take_v : cmp_idx_ff;
   assign page_raddr = nage_raddr;

   // unwritten links read as their reset values
   assign nfree_eff = rd_nfree_vld_ff ? nfree_rdata :
                      ((rd_addr_ff == pva_pkg::LAST_VOICE) ? '0 :
                       pva_pkg::voice_type'(rd_addr_ff + 1'b1));
   assign nage_eff  = rd_nage_vld_ff ? nage_rdata : '0;
   assign page_eff  = rd_page_vld_ff ? page_rdata : '0;

   assign res_load = (state_ff == pva_pkg::ST_DONE) && res_free;
   assign res_data = result_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pva_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (in_opcode == pva_pkg::OP_PRESS) ? pva_pkg::ST_TAKE
                                                            : pva_pkg::ST_SCAN;
            end
         end
         pva_pkg::ST_TAKE:      state_in = pva_pkg::ST_TAKE_LINK;
         pva_pkg::ST_TAKE_LINK: state_in = pva_pkg::ST_DONE;
         pva_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = pva_pkg::ST_FREE_LINK;
            end else if (cmp_live_ff && last) begin
               state_in = pva_pkg::ST_DONE;
            end
         end
         pva_pkg::ST_FREE_LINK: state_in = pva_pkg::ST_DONE;
         pva_pkg::ST_DONE: begin
            if (res_free) begin
               state_in = pva_pkg::ST_IDLE;
            end
         end
         default: state_in = pva_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      vel_in       = vel_ff;
      voice_in     = voice_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = scan_idx_ff;
      cmp_live_in  = 1'b0;
      busy_in      = busy_ff;
      nfree_vld_in = nfree_vld_ff;
      nage_vld_in  = nage_vld_ff;
      page_vld_in  = page_vld_ff;
      count_in     = count_ff;
      ob_in        = ob_ff;
      yb_in        = yb_ff;
      of_in        = of_ff;
      yf_in        = yf_ff;
      result_in    = result_ff;
      rd_addr_in      = take_v;
      rd_nfree_vld_in = nfree_vld_ff[take_v];
      rd_nage_vld_in  = nage_vld_ff[nage_raddr];
      rd_page_vld_in  = page_vld_ff[page_raddr];
      key_we      = 1'b0;
      nfree_we    = 1'b0;
      nfree_waddr = yf_ff;
      nfree_wdata = cmp_idx_ff;
      nage_we     = 1'b0;
      nage_waddr  = take_tail;
      nage_wdata  = take_v;
      page_we     = 1'b0;
      page_waddr  = take_v;
      page_wdata  = take_tail;

      unique case (state_ff)
         pva_pkg::ST_IDLE: begin
            scan_idx_in = '0;
            if (accept) begin
               key_in = in_key;
               vel_in = in_vel;
            end
         end
         pva_pkg::ST_TAKE: begin
            if (!full && empty) begin
               ob_in = of_ff;
            end
            if (!full) begin
               count_in = pva_pkg::count_type'(count_ff + 1'b1);
            end
            key_we   = 1'b1;
            page_we  = 1'b1;
            nage_we  = 1'b1;
            page_vld_in[take_v]    = 1'b1;
            nage_vld_in[take_tail] = 1'b1;
            busy_in[take_v] = 1'b1;
            yb_in    = take_v;
            voice_in = take_v;
            result_in.voice_index    = pva_pkg::INDEX_W'(take_v);
            result_in.outcome        = full ? pva_pkg::OUT_STOLEN : pva_pkg::OUT_ASSIGNED;
            result_in.voice_key      = key_ff;
            result_in.voice_velocity = vel_ff;
         end
         pva_pkg::ST_TAKE_LINK: begin
            if (result_ff.outcome == pva_pkg::OUT_STOLEN) begin
               ob_in = nage_eff;
            end else begin
               of_in = nfree_eff;
            end
         end
         pva_pkg::ST_SCAN: begin
            cmp_live_in = !hit;
            if (scan_idx_ff != pva_pkg::LAST_VOICE) begin
               scan_idx_in = pva_pkg::voice_type'(scan_idx_ff + 1'b1);
            end
            if (hit) begin
               nfree_we = 1'b1;
               nfree_vld_in[yf_ff] = 1'b1;
               yf_in = cmp_idx_ff;
               if (full) begin
                  of_in = cmp_idx_ff;
               end
               if (!empty) begin
                  count_in = pva_pkg::count_type'(count_ff - 1'b1);
               end
               busy_in[cmp_idx_ff] = 1'b0;
               voice_in = cmp_idx_ff;
               result_in.voice_index    = pva_pkg::INDEX_W'(cmp_idx_ff);
               result_in.outcome        = pva_pkg::OUT_RELEASED;
               result_in.voice_key      = '0;
               result_in.voice_velocity = '0;
            end else if (cmp_live_ff && last) begin
               result_in.voice_index    = '0;
               result_in.outcome        = pva_pkg::OUT_NOT_FOUND;
               result_in.voice_key      = '0;
               result_in.voice_velocity = '0;
            end
         end
         pva_pkg::ST_FREE_LINK: begin
            nage_waddr = page_eff;
            nage_wdata = nage_eff;
            page_waddr = nage_eff;
            page_wdata = page_eff;
            priority if (ob_ff == voice_ff) begin
               ob_in = nage_eff;
            end else if (yb_ff == voice_ff) begin
               yb_in = page_eff;
            end else begin
               nage_we = 1'b1;
               page_we = 1'b1;
               nage_vld_in[page_eff] = 1'b1;
               page_vld_in[nage_eff] = 1'b1;
            end
         end
         pva_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::ST_IDLE;
         cmp_live_ff  <= 1'b0;
         busy_ff      <= '0;
         nfree_vld_ff <= '0;
         nage_vld_ff  <= '0;
         page_vld_ff  <= '0;
         count_ff     <= '0;
         ob_ff        <= '0;
         yb_ff        <= '0;
         of_ff        <= '0;
         yf_ff        <= pva_pkg::LAST_VOICE;
      end else begin
         state_ff     <= state_in;
         cmp_live_ff  <= cmp_live_in;
         busy_ff      <= busy_in;
         nfree_vld_ff <= nfree_vld_in;
         nage_vld_ff  <= nage_vld_in;
         page_vld_ff  <= page_vld_in;
         count_ff     <= count_in;
         ob_ff        <= ob_in;
         yb_ff        <= yb_in;
         of_ff        <= of_in;
         yf_ff        <= yf_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      vel_ff          <= vel_in;
      voice_ff        <= voice_in;
      scan_idx_ff     <= scan_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      rd_addr_ff      <= rd_addr_in;
      rd_nfree_vld_ff <= rd_nfree_vld_in;
      rd_nage_vld_ff  <= rd_nage_vld_in;
      rd_page_vld_ff  <= rd_page_vld_in;
      result_ff       <= result_in;
   end

endmodule

@@ sv/polyphonic_voice_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit
// Key press: the item steps through TAKE, TAKE_LINK and DONE to the output register.
// Key release: SCAN steps through the voices with the one-voice-per-cycle key compare
// over the held-key RAM up to a hit or the last voice, then FREE_LINK on a hit, then
// DONE; a stalled result register holds DONE and adds its stall.
// One item in flight; ready returns once the result enters the output register.
// Synchronous reset empties the age list and orders the free list 0 upward.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_unit (
   input logic         clock,
   input logic         reset,
   pva_req_if.sink     req_if,
   pva_rsp_if.source   rsp_if
);

   logic                res_free;
   logic                res_load;
   pva_pkg::result_type res_data;
   logic                rsp_valid_ff, rsp_valid_in;
   pva_pkg::result_type rsp_data_ff, rsp_data_in;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_opcode (req_if.opcode),
      .in_key    (req_if.key_number),
      .in_vel    (req_if.key_velocity),
      .in_ready  (req_if.ready),
      .res_free  (res_free),
      .res_load  (res_load),
      .res_data  (res_data)
   );

   assign res_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.voice_index    = rsp_data_ff.voice_index;
   assign rsp_if.outcome        = rsp_data_ff.outcome;
   assign rsp_if.voice_key      = rsp_data_ff.voice_key;
   assign rsp_if.voice_velocity = rsp_data_ff.voice_velocity;

endmodule

@@ sv/pva_checker.sv @@
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pva_pkg::INDEX_W-1:0] rsp_voice_index,
   input logic [1:0]                  rsp_outcome,
   input pva_pkg::key_type            rsp_voice_key,
   input pva_pkg::vel_type            rsp_voice_velocity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_voice_index)
         && $stable(rsp_outcome) && $stable(rsp_voice_key) && $stable(rsp_voice_velocity))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item was accepted");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == 2'(pva_pkg::OUT_NOT_FOUND)) |->
         (rsp_voice_index == '0) && (rsp_voice_key == '0) && (rsp_voice_velocity == '0))
      else $error("unmatched release reported nonzero fields");

   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == 2'(pva_pkg::OUT_RELEASED)) |->
         (rsp_voice_key == '0) && (rsp_voice_velocity == '0))
      else $error("release reported a key or velocity");

endmodule

bind polyphonic_voice_allocator_unit pva_checker u_pva_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_voice_index    (rsp_if.voice_index),
   .rsp_outcome        (rsp_if.outcome),
   .rsp_voice_key      (rsp_if.voice_key),
   .rsp_voice_velocity (rsp_if.voice_velocity)
);

@@ verif/pva_voice_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pva_voice_checker
// Watches the event and result channels of the voice allocator. Keeps its own
// copy of the free list and the age list, works out the voice, outcome, key
// and velocity that each accepted event must give, and compares them in order
// against the accepted results. Reports mismatches and the number in flight.
// ----------------------------------------------------------------------------
module pva_voice_checker
   import pva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pva_req_if          note_in,
   pva_rsp_if          voice_out,
   output int unsigned failures,
   output int unsigned outstanding
);

   key_type     held[VOICE_COUNT];
   bit          busy[VOICE_COUNT];
   voice_type   age_next[VOICE_COUNT];
   voice_type   age_prev[VOICE_COUNT];
   voice_type   free_next[VOICE_COUNT];
   int          busy_n;
   voice_type   age_head;
   voice_type   age_tail;
   voice_type   free_head;
   voice_type   free_tail;

   result_type  pending_voice_results[$];
   int unsigned mismatch_count;

   function automatic void clear_voice_lists();
      for (int i = 0; i < VOICE_COUNT; i++) begin
         held[i]      = '0;
         busy[i]      = 1'b0;
         age_next[i]  = '0;
         age_prev[i]  = '0;
         free_next[i] = voice_type'((i + 1) % VOICE_COUNT);
      end
      busy_n    = 0;
      age_head  = '0;
      age_tail  = '0;
      free_head = '0;
      free_tail = LAST_VOICE;
   endfunction

   function automatic result_type route_note(opcode_type op, key_type key, vel_type vel);
      result_type r;
      voice_type  v;
      voice_type  p;
      voice_type  n;
      bit         found;
      r = '0;
      v = '0;
      found = 1'b0;
      if (op == OP_PRESS) begin
         if (busy_n < VOICE_COUNT) begin
            if (busy_n == 0) begin
               age_head = free_head;
               age_tail = free_head;
            end
            v = free_head;
            free_head = free_next[v];
            busy_n++;
            r.outcome = OUT_ASSIGNED;
         end else begin
            v = age_head;
            age_head = age_next[v];
            r.outcome = OUT_STOLEN;
         end
         age_prev[v] = age_tail;
         age_next[age_tail] = v;
         age_tail = v;
         held[v] = key;
         busy[v] = 1'b1;
         r.voice_index    = INDEX_W'(v);
         r.voice_key      = key;
         r.voice_velocity = vel;
         return r;
      end

      for (int i = 0; i < VOICE_COUNT; i++) begin
         if (!found && busy[i] && held[i] == key) begin
            found = 1'b1;
            v = voice_type'(i);
         end
      end
      if (!found) begin
         r.outcome = OUT_NOT_FOUND;
         return r;
      end

      free_next[free_tail] = v;
      free_tail = v;
      if (busy_n >= VOICE_COUNT) free_head = v;
      if (busy_n > 0) busy_n--;

      if (age_head == v) begin
         age_head = age_next[v];
      end else if (age_tail == v) begin
         age_tail = age_prev[v];
      end else begin
         p = age_prev[v];
         n = age_next[v];
         age_next[p] = n;
         age_prev[n] = p;
      end

      busy[v] = 1'b0;
      held[v] = '0;
      r.voice_index = INDEX_W'(v);
      r.outcome     = OUT_RELEASED;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin
      mismatch_count = 0;
      clear_voice_lists();
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_voice_lists();
         pending_voice_results.delete();
      end else begin
         if (voice_out.valid && voice_out.ready) begin
            if (pending_voice_results.size() == 0) begin
               $error("result with none expected: voice_index %0d outcome %0d",
                      voice_out.voice_index, voice_out.outcome);
               mismatch_count++;
            end else begin
               want = pending_voice_results.pop_front();
               check_field("voice_index", 8'(want.voice_index), 8'(voice_out.voice_index));
               check_field("outcome", 8'(want.outcome), 8'(voice_out.outcome));
               check_field("voice_key", 8'(want.voice_key), 8'(voice_out.voice_key));
               check_field("voice_velocity", 8'(want.voice_velocity),
                           8'(voice_out.voice_velocity));
            end
         end
         if (note_in.valid && note_in.ready)
            pending_voice_results.push_back(route_note(opcode_type'(note_in.opcode),
                                                       note_in.key_number,
                                                       note_in.key_velocity));
      end
      outstanding <= pending_voice_results.size();
      failures    <= mismatch_count;
   end

endmodule

@@ verif/tb_polyphonic_voice_allocator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphonic_voice_allocator_unit
// Drives key press and key release events into the voice allocator: a
// directed pass that fills every voice, steals, and releases the oldest, the
// youngest, a middle voice, a duplicate key and an unheld key, then random
// fill and drain rounds with bursty events and a stalling result receiver.
// A checker module beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_allocator_unit;
   import pva_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * VOICE_COUNT + 8;

   logic        clock;
   logic        reset;
   int unsigned failures;
   int unsigned outstanding;
   int          idle_cycles = 0;
   int          burst_left  = 0;
   bit          steady_burst = 1'b0;
   key_type     held_keys[$];

   pva_req_if note_req ();
   pva_rsp_if voice_rsp ();

   polyphonic_voice_allocator_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (note_req),
      .rsp_if (voice_rsp)
   );

   pva_voice_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .note_in     (note_req),
      .voice_out   (voice_rsp),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (note_req.valid && note_req.ready) || (voice_rsp.valid && voice_rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_polyphonic_voice_allocator_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      int mode;
      phase = 0;
      mode  = 0;
      voice_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == 0) mode = $urandom_range(0, 3);
         phase = (phase + 1) % 32;
         case (mode)
            0: voice_rsp.ready <= 1'b1;
            1: voice_rsp.ready <= ($urandom_range(0, 3) != 0);
            2: voice_rsp.ready <= ($urandom_range(0, 3) == 0);
            default: voice_rsp.ready <= ((phase % 8) < 5);
         endcase
      end
   end

   task automatic send_note(input opcode_type op, input key_type key, input vel_type vel);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = steady_burst ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            note_req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      note_req.valid        <= 1'b1;
      note_req.opcode       <= op;
      note_req.key_number   <= key;
      note_req.key_velocity <= vel;
      do @(posedge clock); while (!note_req.ready);
      burst_left--;
   endtask

   task automatic press_key(input key_type key, input vel_type vel);
      held_keys.push_back(key);
      send_note(OP_PRESS, key, vel);
   endtask

   task automatic release_key(input key_type key);
      int idx;
      idx = -1;
      foreach (held_keys[i])
         if (idx < 0 && held_keys[i] == key) idx = i;
      if (idx >= 0) held_keys.delete(idx);
      send_note(OP_RELEASE, key, vel_type'($urandom()));
   endtask

   task automatic release_held_key();
      int idx;
      key_type key;
      idx = $urandom_range(0, held_keys.size() - 1);
      key = held_keys[idx];
      held_keys.delete(idx);
      send_note(OP_RELEASE, key, vel_type'($urandom()));
   endtask

   task automatic wait_for_voices();
      note_req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(0, 9) < 3) return key_type'($urandom_range(60, 63));
      return key_type'($urandom_range(0, 127));
   endfunction

   initial begin
      int random_sent;
      int target;
      int pick;
      reset                 <= 1'b1;
      note_req.valid        <= 1'b0;
      note_req.opcode       <= OP_RELEASE;
      note_req.key_number   <= '0;
      note_req.key_velocity <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill every voice; one key pressed twice
      for (int i = 0; i < VOICE_COUNT; i++)
         press_key((i == 5) ? key_type'(16) :
                   (i == VOICE_COUNT - 1) ? key_type'(127) : key_type'(i * 8),
                   (i == 0) ? vel_type'(127) :
                   (i == VOICE_COUNT - 1) ? vel_type'(0) : vel_type'(i * 8 + 3));
      press_key(key_type'(127), vel_type'(127));
      release_key(key_type'(16));
      release_key(key_type'(8));
      release_key(key_type'(127));
      release_key(key_type'(100));
      release_key(key_type'(16));
      release_key(key_type'(127));
      release_key(key_type'(0));
      press_key(key_type'(5), vel_type'(1));

      wait_for_voices();
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         target = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         steady_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) wait_for_voices();
         while (held_keys.size() != target && random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               release_key(key_type'($urandom()));
            else if ((held_keys.size() < target) == (pick >= 20) || held_keys.size() == 0)
               press_key(pick_key(), vel_type'($urandom()));
            else
               release_held_key();
            random_sent++;
         end
      end

      wait_for_voices();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("tb_polyphonic_voice_allocator_unit: PASS");
      else
         $display("tb_polyphonic_voice_allocator_unit: FAIL");
      $finish;
   end

endmodule
